// ===== sv/lcd_three_wire_write_serializer_core_macros.svh =====
// Assertion macros shared by the serializer modules.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef LCD_THREE_WIRE_WRITE_SERIALIZER_CORE_MACROS_SVH
`define LCD_THREE_WIRE_WRITE_SERIALIZER_CORE_MACROS_SVH

// Implication checked on every rising edge outside reset
`define LCDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define LCDW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/lcdw_pkg.sv =====
// Shared types and codes for the three-wire LCD write serializer.
// No dependencies.
package lcdw_pkg;

  // Request kinds carried in tuser
  localparam logic [1:0] REQ_CMD  = 2'd0;
  localparam logic [1:0] REQ_ADDR = 2'd1;
  localparam logic [1:0] REQ_DATA = 2'd2;
  localparam logic [1:0] REQ_STOP = 2'd3;

  // Frame prefixes, sent MSB first
  localparam logic [2:0] PFX_CMD  = 3'b100;
  localparam logic [2:0] PFX_ADDR = 3'b101;

  // Bit counts per frame
  localparam logic [3:0] NBITS_CMD  = 4'd12;
  localparam logic [3:0] NBITS_ADDR = 4'd9;
  localparam logic [3:0] NBITS_DATA = 4'd8;

  localparam int unsigned SHIFT_W = 12;
  localparam int unsigned QDEPTH  = 2;

  // One classified request: bits left-aligned, sent MSB first
  typedef struct packed {
    logic [SHIFT_W-1:0] bits;
    logic [3:0]         nbits;
    logic               sel;   // select phase first
    logic               stop;  // stop phases at the end
  } desc_t;

endpackage

// ===== sv/lcd_three_wire_write_serializer_core.sv =====
// With the queue empty and the sequencer idle, an accepted word is written into the queue
// and the sequencer then registers the first pin phase of the request from the queue head.
// The back-end sequencer emits one pin phase per cycle while the receiver takes them, so a
// data byte is 16 phases, an address 19, a command 27 and a stop 2; a 2-entry queue
// lets requests be accepted while earlier ones are still being clocked out.
// Reset: queue empty, no output word, chip select, strobe and data idle high.
module lcd_three_wire_write_serializer_core import lcdw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // value[7:0]
  input  logic [1:0] s_axis_tuser_i,   // req_type[1:0]
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // cs_level, wr_level, data_level, zero pad
  output logic       m_axis_tlast_o    // last_phase
);

  logic  push, full, head_valid, pop;
  desc_t desc, head;

  // Request classification
  lcdw_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (full),
    .push_o          (push),
    .desc_o          (desc)
  );

  // Decoupling queue
  lcdw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (desc),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Pin phase sequencer
  lcdw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== sv/lcdw_front.sv =====
// Front end: takes request words and turns them into bit descriptors.
// Depends on lcdw_pkg.
module lcdw_front import lcdw_pkg::*; (
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // value[7:0]
  input  logic [1:0] s_axis_tuser_i,   // req_type[1:0]
  input  logic       q_full_i,
  output logic       push_o,
  output desc_t      desc_o
);

  logic [7:0] rev;

  // Data bytes go LSB first: reverse so the back end always shifts MSB first
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev[i] = s_axis_tdata_i[7-i];
    end
  end

  // Classify the request
  always_comb begin
    desc_o = '0;
    case (s_axis_tuser_i)
      REQ_CMD: begin
        desc_o.bits  = {PFX_CMD, s_axis_tdata_i, 1'b0};
        desc_o.nbits = NBITS_CMD;
        desc_o.sel   = 1'b1;
        desc_o.stop  = 1'b1;
      end
      REQ_ADDR: begin
        desc_o.bits  = {PFX_ADDR, s_axis_tdata_i[5:0], 3'b000};
        desc_o.nbits = NBITS_ADDR;
        desc_o.sel   = 1'b1;
      end
      REQ_DATA: begin
        desc_o.bits  = {rev, 4'b0000};
        desc_o.nbits = NBITS_DATA;
      end
      default: begin
        desc_o.stop  = 1'b1;
      end
    endcase
  end

  assign s_axis_tready_o = !q_full_i;
  assign push_o          = s_axis_tvalid_i && !q_full_i;

endmodule

// ===== sv/lcdw_queue.sv =====
// Two-entry descriptor queue between front and back end.
// Depends on lcdw_pkg and the assertion macro header.
`include "lcd_three_wire_write_serializer_core_macros.svh"
module lcdw_queue import lcdw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  output logic  full_o,
  output logic  head_valid_o,
  output desc_t head_o,
  input  logic  pop_i
);

  desc_t      mem_q [QDEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  assign full_o       = (count_q == 2'(QDEPTH));
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  `LCDW_NEVER(a_q_overfill, count_q > 2'(QDEPTH), "queue fill count beyond depth")
  `LCDW_NEVER(a_q_pop_empty, pop_i && (count_q == 2'd0), "pop from empty queue")
  `LCDW_ASSERT(a_q_ptr_match, (count_q == 2'd0 || count_q == 2'(QDEPTH)) |-> (wr_ptr_q == rd_ptr_q), "pointers disagree with fill count")

endmodule

// ===== sv/lcdw_back.sv =====
// Back end: walks a descriptor and emits one pin phase per word.
// Depends on lcdw_pkg and the assertion macro header.
`include "lcd_three_wire_write_serializer_core_macros.svh"
module lcdw_back import lcdw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  desc_t      head_i,
  output logic       pop_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // cs_level, wr_level, data_level, zero pad
  output logic       m_axis_tlast_o   // last_phase
);

  // Sequencer steps: the phase to emit next
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SEL   = 3'd1;
  localparam logic [2:0] ST_LOW   = 3'd2;
  localparam logic [2:0] ST_HIGH  = 3'd3;
  localparam logic [2:0] ST_STOP1 = 3'd4;
  localparam logic [2:0] ST_STOP2 = 3'd5;

  logic [2:0]         st_q, st_d;
  logic [SHIFT_W-1:0] bits_q, bits_d;
  logic [3:0]         left_q, left_d;
  logic               stop_q, stop_d;
  logic               cs_q, cs_d, wr_q, wr_d, dat_q, dat_d;
  logic               vld_q, vld_d;
  logic               last_q, last_d;

  logic               adv, go;
  logic [2:0]         step;
  logic [SHIFT_W-1:0] e_bits;
  logic [3:0]         e_left;
  logic               e_stop;

  assign adv = !vld_q || m_axis_tready_i;

  // Pick the working descriptor: a fresh one from the queue when idle
  always_comb begin
    if (st_q == ST_IDLE) begin
      go     = head_valid_i;
      e_bits = head_i.bits;
      e_left = head_i.nbits;
      e_stop = head_i.stop;
      if (head_i.sel) begin
        step = ST_SEL;
      end else if (head_i.nbits != 4'd0) begin
        step = ST_LOW;
      end else begin
        step = ST_STOP1;
      end
    end else begin
      go     = 1'b1;
      e_bits = bits_q;
      e_left = left_q;
      e_stop = stop_q;
      step   = st_q;
    end
  end

  assign pop_o = adv && (st_q == ST_IDLE) && head_valid_i;

  // Phase generation
  always_comb begin
    st_d   = st_q;
    bits_d = bits_q;
    left_d = left_q;
    stop_d = stop_q;
    cs_d   = cs_q;
    wr_d   = wr_q;
    dat_d  = dat_q;
    vld_d  = vld_q;
    last_d = last_q;
    if (adv) begin
      vld_d = go;
      if (go) begin
        bits_d = e_bits;
        left_d = e_left;
        stop_d = e_stop;
        last_d = 1'b0;
        case (step)
          ST_SEL: begin
            cs_d = 1'b0;
            st_d = ST_LOW;
          end
          ST_LOW: begin
            wr_d  = 1'b0;
            dat_d = e_bits[SHIFT_W-1];
            st_d  = ST_HIGH;
          end
          ST_HIGH: begin
            wr_d   = 1'b1;
            bits_d = {e_bits[SHIFT_W-2:0], 1'b0};
            left_d = e_left - 4'd1;
            if (e_left != 4'd1) begin
              st_d = ST_LOW;
            end else if (e_stop) begin
              st_d = ST_STOP1;
            end else begin
              st_d   = ST_IDLE;
              last_d = 1'b1;
            end
          end
          ST_STOP1: begin
            cs_d = 1'b1;
            st_d = ST_STOP2;
          end
          ST_STOP2: begin
            dat_d  = 1'b1;
            st_d   = ST_IDLE;
            last_d = 1'b1;
          end
          default: begin
            st_d = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cs_q  <= 1'b1;
      wr_q  <= 1'b1;
      dat_q <= 1'b1;
      vld_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cs_q  <= cs_d;
      wr_q  <= wr_d;
      dat_q <= dat_d;
      vld_q <= vld_d;
    end
  end

  // Descriptor working copy and last flag
  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    left_q <= left_d;
    stop_q <= stop_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = {5'b00000, dat_q, wr_q, cs_q};
  assign m_axis_tlast_o  = last_q;

  `LCDW_ASSERT(a_b_last_strobe_high, (vld_q && last_q) |-> wr_q, "request ended with strobe low")
  `LCDW_ASSERT(a_b_high_after_low, (st_q == ST_HIGH) |-> (!wr_q && vld_q), "high phase pending without low phase shown")
  `LCDW_ASSERT(a_b_bits_left, ((st_q == ST_LOW) || (st_q == ST_HIGH)) |-> (left_q != 4'd0), "bit phase with no bits left")
  `LCDW_ASSERT(a_b_stop2_cs, (st_q == ST_STOP2) |-> cs_q, "second stop phase pending with chip select low")

endmodule

// ===== sim/lcd_three_wire_write_serializer_core_tb.sv =====
// Self-checking bench for lcd_three_wire_write_serializer_core: streams requests, predicts pin
// phases in-bench and compares every output word. Depends on lcdw_pkg and the core only.
module lcd_three_wire_write_serializer_core_tb import lcdw_pkg::*;;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int N_DIRECTED     = 20;

  // One pin phase as seen on the output: levels after the phase plus end-of-request flag
  typedef struct packed {
    logic cs;
    logic wr;
    logic dat;
    logic last;
  } pin_phase_t;

  // Directed row; exp_a/exp_b are only filled in for stop rows
  typedef struct packed {
    logic       typed;
    logic [1:0] req;
    logic [7:0] val;
    pin_phase_t exp_a;
    pin_phase_t exp_b;
  } dir_row_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;
  logic [1:0] s_axis_tuser_i  = REQ_CMD;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;

  // Predicted pin levels
  logic cs_lvl  = 1'b1;
  logic wr_lvl  = 1'b1;
  logic dat_lvl = 1'b1;

  pin_phase_t pin_phase_q [$];
  pin_phase_t want_phase;
  pin_phase_t got_phase;
  dir_row_t   dir_tab [N_DIRECTED];

  int  mismatch_cnt = 0;
  int  cycle_cnt    = 0;
  int  items_sent   = 0;
  bit  idle_on      = 1'b0;
  bit  quiet        = 1'b0;
  bit  rx_hold      = 1'b0;

  lcd_three_wire_write_serializer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  task automatic emit_phase();
    pin_phase_q.push_back({cs_lvl, wr_lvl, dat_lvl, 1'b0});
  endtask

  // strobe low with the data level, then strobe high holding it
  task automatic clock_bit(input logic b);
    wr_lvl  = 1'b0;
    dat_lvl = b;
    emit_phase();
    wr_lvl  = 1'b1;
    emit_phase();
  endtask

  task automatic end_frame();
    cs_lvl = 1'b1;
    emit_phase();
    dat_lvl = 1'b1;
    emit_phase();
  endtask

  task automatic serialize_request(input logic [1:0] req, input logic [7:0] val);
    logic [11:0] cmd_bits;
    logic [8:0]  addr_bits;
    pin_phase_t  tail;
    cmd_bits  = {PFX_CMD, val, 1'b0};
    addr_bits = {PFX_ADDR, val[5:0]};   // top two bits of an address are dropped
    case (req)
      REQ_CMD: begin
        cs_lvl = 1'b0;
        emit_phase();
        for (int i = 11; i >= 0; i--) clock_bit(cmd_bits[i]);
        end_frame();
      end
      REQ_ADDR: begin
        cs_lvl = 1'b0;
        emit_phase();
        for (int i = 8; i >= 0; i--) clock_bit(addr_bits[i]);
      end
      REQ_DATA: begin
        for (int i = 0; i < 8; i++) clock_bit(val[i]);   // LSB first, cs untouched
      end
      default: begin
        end_frame();
      end
    endcase
    tail = pin_phase_q.pop_back();
    tail.last = 1'b1;
    pin_phase_q.push_back(tail);
  endtask

  // ---------------------------------------------------------------- sender
  task automatic send_req(input logic [1:0] req, input logic [7:0] val);
    if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= val;
    s_axis_tuser_i  <= req;
    do @(posedge clk_i); while (!s_axis_tready_o);
    serialize_request(req, val);
    items_sent++;
  endtask

  // Half well-formed transfers (address, data bytes, stop), the rest some commands and some noise
  task automatic send_random_burst();
    int kind;
    int n;
    kind    = $urandom_range(0, 9);
    idle_on = ($urandom_range(0, 2) != 0);
    if (kind < 5) begin
      send_req(REQ_ADDR, 8'($urandom_range(0, 255)));
      n = $urandom_range(1, 6);
      repeat (n) send_req(REQ_DATA, 8'($urandom_range(0, 255)));
      send_req(REQ_STOP, 8'($urandom_range(0, 255)));
    end else if (kind < 7) begin
      send_req(REQ_CMD, 8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold = 1'b0;
      end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_phase = {m_axis_tdata_o[0], m_axis_tdata_o[1], m_axis_tdata_o[2], m_axis_tlast_o};
      if (pin_phase_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected output word tdata=%h tlast=%b",
                   $time, m_axis_tdata_o, m_axis_tlast_o);
      end else begin
        want_phase = pin_phase_q.pop_front();
        if (got_phase !== want_phase || m_axis_tdata_o[7:3] !== 5'b0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: expected cs=%b wr=%b data=%b last=%b, got tdata=%h tlast=%b",
                     $time, want_phase.cs, want_phase.wr, want_phase.dat, want_phase.last,
                     m_axis_tdata_o, m_axis_tlast_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    dir_tab = '{
      {1'b1, REQ_STOP, 8'h00, 4'b1110, 4'b1111},  // stop straight after reset
      {1'b0, REQ_DATA, 8'h00, 8'h00},             // data while deselected
      {1'b1, REQ_STOP, 8'h00, 4'b1100, 4'b1111},  // data line still low from last bit
      {1'b1, REQ_STOP, 8'hFF, 4'b1110, 4'b1111},  // stop while deselected
      {1'b0, REQ_CMD,  8'h00, 8'h00},
      {1'b0, REQ_CMD,  8'hFF, 8'h00},
      {1'b0, REQ_CMD,  8'hA5, 8'h00},
      {1'b0, REQ_ADDR, 8'h00, 8'h00},
      {1'b0, REQ_DATA, 8'hFF, 8'h00},
      {1'b0, REQ_DATA, 8'h00, 8'h00},
      {1'b0, REQ_ADDR, 8'h3F, 8'h00},             // select while already selected
      {1'b0, REQ_ADDR, 8'hC0, 8'h00},             // wide address, top bits ignored
      {1'b0, REQ_ADDR, 8'hFF, 8'h00},
      {1'b0, REQ_DATA, 8'h5A, 8'h00},
      {1'b0, REQ_DATA, 8'h80, 8'h00},
      {1'b1, REQ_STOP, 8'h7E, 4'b1110, 4'b1111},
      {1'b0, REQ_CMD,  8'h3C, 8'h00},
      {1'b0, REQ_ADDR, 8'h2A, 8'h00},
      {1'b1, REQ_STOP, 8'h00, 4'b1100, 4'b1111},
      {1'b0, REQ_DATA, 8'h01, 8'h00}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; stop rows carry their phases typed in
    idle_on = 1'b1;
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_req(dir_tab[i].req, dir_tab[i].val);
      if (dir_tab[i].typed) begin
        void'(pin_phase_q.pop_back());
        void'(pin_phase_q.pop_back());
        pin_phase_q.push_back(dir_tab[i].exp_a);
        pin_phase_q.push_back(dir_tab[i].exp_b);
      end
    end

    while (items_sent < N_DIRECTED + 40) send_random_burst();

    // long receiver hold while words keep coming, so the input stalls
    idle_on = 1'b0;
    rx_hold = 1'b1;
    send_req(REQ_ADDR, 8'($urandom_range(0, 255)));
    repeat (10) send_req(REQ_DATA, 8'($urandom_range(0, 255)));
    send_req(REQ_STOP, 8'($urandom_range(0, 255)));

    // let everything drain before carrying on
    s_axis_tvalid_i <= 1'b0;
    while (pin_phase_q.size() != 0) @(posedge clk_i);

    while (items_sent < N_DIRECTED + 75) send_random_burst();

    // closing stretch at full rate on both sides
    quiet = 1'b1;
    while (items_sent < N_DIRECTED + 100) send_random_burst();

    s_axis_tvalid_i <= 1'b0;
    while (pin_phase_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatch_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
